@@ hdl/pcs_pkg.sv @@
`default_nettype none

package pcs_pkg;

  // Duty waveform geometry
  localparam int unsigned DutySteps = 8;
  localparam int unsigned DutyPosW  = $clog2(DutySteps);

  // Field widths
  localparam int unsigned PeriodW    = 11;
  localparam int unsigned FreqCntW   = 14;
  localparam int unsigned LengthW    = 7;
  localparam int unsigned LevelW     = 5;

  // Limits
  localparam logic [PeriodW:0]   PeriodSpan = 12'd2048;
  localparam logic [LengthW-1:0] LengthFull = 7'd64;
  localparam logic [3:0]         VolumeMax  = 4'd15;
  localparam logic [3:0]         PaceZero   = 4'd8;

  // Read masks
  localparam logic [7:0] DutyReadMask  = 8'hC0;
  localparam logic [7:0] HighReadMask  = 8'h78;
  localparam logic [7:0] UnmappedRead  = 8'hFF;

  // Transaction kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // Register offsets
  typedef enum logic [2:0] {
    REG_SWEEP   = 3'd0,
    REG_DUTYLEN = 3'd1,
    REG_ENV     = 3'd2,
    REG_PLOW    = 3'd3,
    REG_PHIGH   = 3'd4
  } reg_off_e;

  // Frame sequencer step that clocks the envelope
  localparam logic [2:0] EnvStep = 3'd7;

  // Duty waveforms, bit i is waveform step i
  localparam logic [DutySteps-1:0] DUTY_WAVE [4] = '{
    8'b1000_0000,
    8'b1000_0001,
    8'b1110_0001,
    8'b0111_1110
  };

  typedef struct packed {
    logic [7:0]               sweep_reg;
    logic [7:0]               duty_length_reg;
    logic [7:0]               envelope_reg;
    logic [7:0]               period_low_reg;
    logic [7:0]               period_high_reg;
    logic [FreqCntW-1:0]      freq_countdown;
    logic [DutyPosW-1:0]      duty_position;
    logic signed [LevelW-1:0] out_level;
    logic                     active;
    logic [LengthW-1:0]       length_left;
    logic [3:0]               volume;
    logic [3:0]               env_countdown;
    logic                     env_finished;
    logic [2:0]               sweep_period;
    logic [3:0]               sweep_countdown;
  } chan_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
    logic [2:0] seq_step;
  } item_t;

  typedef struct packed {
    logic signed [LevelW-1:0] sample;
    logic [7:0]               read_data;
    logic                     channel_on;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/pcs_core.sv @@
`default_nettype none

module pcs_core (
  input  wire pcs_pkg::chan_state_t st_i,
  input  wire pcs_pkg::item_t       item_i,
  output pcs_pkg::chan_state_t      st_o,
  output pcs_pkg::result_t          res_o
);
  import pcs_pkg::*;

  logic [PeriodW-1:0]  period;
  logic [FreqCntW-1:0] reload;
  logic [PeriodW:0]    reload_base;
  logic [PeriodW-1:0]  sw_shifted;
  logic [PeriodW:0]    sw_sum;
  logic [PeriodW:0]    sw_next;
  logic [2:0]          env_pace;
  logic [2:0]          new_pace;
  logic                wave_bit;
  logic [DutyPosW-1:0] next_pos;
  logic [7:0]          rd;
  chan_state_t         s;

  // Current period and frequency timer reload value
  assign period      = {st_i.period_high_reg[2:0], st_i.period_low_reg};
  assign reload_base = PeriodSpan - {1'b0, period};
  assign reload      = {reload_base, 2'b00};

  // Sweep candidate period
  assign sw_shifted = period >> st_i.sweep_reg[2:0];
  assign sw_sum     = {1'b0, period} + {1'b0, sw_shifted};
  assign sw_next    = st_i.sweep_reg[3] ? {1'b0, period - sw_shifted} : sw_sum;

  assign env_pace = st_i.envelope_reg[2:0];
  assign new_pace = item_i.write_data[6:4];
  assign next_pos = st_i.duty_position + 1'b1;
  assign wave_bit = DUTY_WAVE[st_i.duty_length_reg[7:6]][next_pos];

  // Next state for one transaction
  always_comb begin
    s  = st_i;
    rd = '0;
    case (item_i.kind)
      KIND_TICK: begin
        if (st_i.freq_countdown != '0) begin
          s.freq_countdown = st_i.freq_countdown - 1'b1;
        end else begin
          s.freq_countdown = reload;
          s.duty_position  = next_pos;
          if (st_i.active) begin
            s.out_level = wave_bit ? $signed({1'b0, st_i.volume})
                                   : $signed(5'd0 - {1'b0, st_i.volume});
          end else begin
            s.out_level = '0;
          end
        end
      end
      KIND_FRAME: begin
        if (st_i.active) begin
          // Length counter on even steps
          if (!item_i.seq_step[0] && st_i.period_high_reg[6] && st_i.length_left != '0) begin
            s.length_left = st_i.length_left - 1'b1;
            if (st_i.length_left == 7'd1) begin
              s.active = 1'b0;
            end
          end
          // Frequency sweep on steps 2 and 6
          if (item_i.seq_step[1:0] == 2'd2 && st_i.sweep_period != '0) begin
            if (st_i.sweep_countdown == '0) begin
              s.sweep_countdown = {1'b0, st_i.sweep_period};
              if (sw_next[PeriodW]) begin
                s.active = 1'b0;
              end else begin
                s.period_low_reg  = sw_next[7:0];
                s.period_high_reg = {st_i.period_high_reg[7:3], sw_next[10:8]};
              end
            end else begin
              s.sweep_countdown = st_i.sweep_countdown - 1'b1;
            end
          end
          // Volume envelope on the last step
          if (item_i.seq_step == EnvStep && !st_i.env_finished) begin
            if (st_i.env_countdown == '0) begin
              s.env_countdown = (env_pace != '0) ? {1'b0, env_pace} : PaceZero;
              if (st_i.envelope_reg[3] && st_i.volume != VolumeMax) begin
                s.volume = st_i.volume + 1'b1;
              end else if (!st_i.envelope_reg[3] && st_i.volume != '0) begin
                s.volume = st_i.volume - 1'b1;
              end
              if (s.volume == '0 || s.volume == VolumeMax) begin
                s.env_finished = 1'b1;
              end
            end else begin
              s.env_countdown = st_i.env_countdown - 1'b1;
            end
          end
        end
      end
      KIND_WRITE: begin
        case (item_i.reg_offset)
          REG_SWEEP: begin
            if (st_i.sweep_reg[6:4] == '0 && new_pace != '0) begin
              s.sweep_period    = new_pace;
              s.sweep_countdown = {1'b0, new_pace};
            end
            s.sweep_reg = item_i.write_data;
            if (new_pace == '0) begin
              s.sweep_period = '0;
            end
          end
          REG_DUTYLEN: begin
            s.duty_length_reg = item_i.write_data;
            s.length_left     = LengthFull - {1'b0, item_i.write_data[5:0]};
          end
          REG_ENV: begin
            s.envelope_reg = item_i.write_data;
          end
          REG_PLOW: begin
            s.period_low_reg = item_i.write_data;
          end
          REG_PHIGH: begin
            s.period_high_reg = item_i.write_data;
            // Trigger: restart the channel
            if (item_i.write_data[7]) begin
              s.active = 1'b1;
              if (st_i.length_left == '0) begin
                s.length_left = LengthFull - {1'b0, st_i.duty_length_reg[5:0]};
              end
              s.volume          = st_i.envelope_reg[7:4];
              s.env_countdown   = (env_pace != '0) ? {1'b0, env_pace} : PaceZero;
              s.env_finished    = 1'b0;
              s.sweep_period    = st_i.sweep_reg[6:4];
              s.sweep_countdown = (st_i.sweep_reg[6:4] != '0) ?
                                  {1'b0, st_i.sweep_reg[6:4]} : PaceZero;
              s.freq_countdown  =
                {PeriodSpan - {1'b0, item_i.write_data[2:0], st_i.period_low_reg}, 2'b00};
              s.duty_position   = '0;
            end
          end
          default: begin
          end
        endcase
      end
      KIND_READ: begin
        case (item_i.reg_offset)
          REG_SWEEP:   rd = st_i.sweep_reg;
          REG_DUTYLEN: rd = st_i.duty_length_reg & DutyReadMask;
          REG_ENV:     rd = st_i.envelope_reg;
          REG_PLOW:    rd = '0;
          REG_PHIGH:   rd = st_i.period_high_reg & HighReadMask;
          default:     rd = UnmappedRead;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign st_o             = s;
  assign res_o.sample     = s.out_level;
  assign res_o.read_data  = rd;
  assign res_o.channel_on = s.active;

endmodule

`default_nettype wire

@@ hdl/pulse_channel_with_sweep_unit.sv @@
`default_nettype none

// Square-wave sound channel with frequency sweep, volume envelope and length
// counter. Every accepted transaction (period tick, frame sequencer step,
// register write or register read) updates the channel state in the cycle it
// is accepted and produces exactly one result, in order. A new transaction can
// be taken every clock cycle while in_ready_o is high: each result is registered
// into a two-entry output queue, so in_ready_o only drops when two results are
// waiting for out_ready_i.
module pulse_channel_with_sweep_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [2:0]  reg_offset_i,
  input  wire logic [7:0]  write_data_i,
  input  wire logic [2:0]  seq_step_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [pcs_pkg::LevelW-1:0] sample_o,
  output logic [7:0]       read_data_o,
  output logic             channel_on_o
);
  import pcs_pkg::*;

  chan_state_t st_q, st_d;
  item_t       item;
  result_t     res_new;
  result_t     head_q, head_d;
  result_t     tail_q, tail_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign item.kind       = kind_i;
  assign item.reg_offset = reg_offset_i;
  assign item.write_data = write_data_i;
  assign item.seq_step   = seq_step_i;

  pcs_core u_core (
    .st_i   (st_q),
    .item_i (item),
    .st_o   (st_d),
    .res_o  (res_new)
  );

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance the channel state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (push) begin
      st_q <= st_d;
    end
  end

  // Output queue: push new results, drop the head on handoff
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      if (cnt_q == 2'd0) begin
        head_d = res_new;
      end else begin
        tail_d = res_new;
      end
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      head_d = tail_q;
      cnt_d  = cnt_q - 1'b1;
    end else if (push && pop) begin
      head_d = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign sample_o     = head_q.sample;
  assign read_data_o  = head_q.read_data;
  assign channel_on_o = head_q.channel_on;

endmodule

`default_nettype wire

@@ hdl/pcs_checker.sv @@
`default_nettype none

module pcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [4:0]  sample_o,
  input wire logic [7:0]  read_data_o,
  input wire logic        channel_on_o
);
  import pcs_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(sample_o) && $stable(read_data_o) && $stable(channel_on_o))
    else $error("result changed while stalled");

  // Backpressure only when results are waiting
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output queue");

  // Every accepted transaction yields a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after accepted transaction");

  // Level stays within plus or minus full volume
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sample_o != 5'b10000)
    else $error("sample out of range");

endmodule

bind pulse_channel_with_sweep_unit pcs_checker u_pcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_o     (sample_o),
  .read_data_o  (read_data_o),
  .channel_on_o (channel_on_o)
);

`default_nettype wire

@@ tb/pulse_channel_checker.sv @@
// Watches the square-wave channel, predicts one result per
// accepted input transaction and compares every output transaction with the
// oldest prediction.
module pulse_channel_checker
  import pcs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        kind_i,
  input  logic [2:0]        reg_offset_i,
  input  logic [7:0]        write_data_i,
  input  logic [2:0]        seq_step_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic signed [4:0] sample_i,
  input  logic [7:0]        read_data_i,
  input  logic              channel_on_i,
  output int unsigned       error_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned ReportLimit = 10;

  // Duty shapes, bit i is the level at waveform position i
  localparam logic [7:0] WaveShape [4] = '{8'h80, 8'h81, 8'hE1, 8'h7E};

  // Predicted channel state
  logic [7:0]        sweep_cfg, duty_cfg, env_cfg, period_lo, period_hi;
  logic [13:0]       freq_timer;
  logic [2:0]        wave_pos;
  logic signed [4:0] level;
  logic              chan_on;
  logic [6:0]        length_cnt;
  logic [3:0]        vol;
  logic [3:0]        env_timer;
  logic              env_done;
  logic [2:0]        sweep_len;
  logic [3:0]        sweep_cnt;

  result_t     channel_results [$];
  int unsigned fail_count;

  function automatic logic [10:0] period_now();
    return {period_hi[2:0], period_lo};
  endfunction

  function automatic logic [13:0] timer_load();
    logic [11:0] span;
    span = PeriodSpan - {1'b0, period_now()};
    return {span, 2'b00};
  endfunction

  task automatic clear_channel();
    sweep_cfg  = '0;
    duty_cfg   = '0;
    env_cfg    = '0;
    period_lo  = '0;
    period_hi  = '0;
    freq_timer = '0;
    wave_pos   = '0;
    level      = '0;
    chan_on    = 1'b0;
    length_cnt = '0;
    vol        = '0;
    env_timer  = '0;
    env_done   = 1'b0;
    sweep_len  = '0;
    sweep_cnt  = '0;
  endtask

  // Count down the frequency timer; on expiry advance the waveform
  task automatic tick_period();
    if (freq_timer != 0) begin
      freq_timer = freq_timer - 14'd1;
    end else begin
      freq_timer = timer_load();
      wave_pos   = wave_pos + 3'd1;
      if (!chan_on) begin
        level = '0;
      end else if (WaveShape[duty_cfg[7:6]][wave_pos]) begin
        level = {1'b0, vol};
      end else begin
        level = 5'd0 - {1'b0, vol};
      end
    end
  endtask

  // Length on even steps, sweep on steps 2 and 6, envelope on step 7
  task automatic step_frame(logic [2:0] seq);
    logic [11:0] p, delta;
    if (chan_on) begin
      if (!seq[0] && period_hi[6] && length_cnt != 0) begin
        length_cnt = length_cnt - 7'd1;
        if (length_cnt == 0) chan_on = 1'b0;
      end
      if (seq[1:0] == 2'd2 && sweep_len != 0) begin
        if (sweep_cnt == 0) begin
          sweep_cnt = {1'b0, sweep_len};
          p     = {1'b0, period_now()};
          delta = p >> sweep_cfg[2:0];
          p     = sweep_cfg[3] ? p - delta : p + delta;
          if (p > 12'h7FF) begin
            chan_on = 1'b0;
          end else begin
            period_lo = p[7:0];
            period_hi = {period_hi[7:3], p[10:8]};
          end
        end else begin
          sweep_cnt = sweep_cnt - 4'd1;
        end
      end
      if (seq == EnvStep && !env_done) begin
        if (env_timer == 0) begin
          env_timer = (env_cfg[2:0] != 0) ? {1'b0, env_cfg[2:0]} : PaceZero;
          if (env_cfg[3] && vol < VolumeMax) vol = vol + 4'd1;
          else if (!env_cfg[3] && vol > 0) vol = vol - 4'd1;
          if (vol == 0 || vol == VolumeMax) env_done = 1'b1;
        end else begin
          env_timer = env_timer - 4'd1;
        end
      end
    end
  endtask

  task automatic write_register(logic [2:0] off, logic [7:0] d);
    case (off)
      REG_SWEEP: begin
        if (sweep_cfg[6:4] == 0 && d[6:4] != 0) begin
          sweep_len = d[6:4];
          sweep_cnt = {1'b0, d[6:4]};
        end
        sweep_cfg = d;
        if (d[6:4] == 0) sweep_len = '0;
      end
      REG_DUTYLEN: begin
        duty_cfg   = d;
        length_cnt = LengthFull - {1'b0, d[5:0]};
      end
      REG_ENV:  env_cfg   = d;
      REG_PLOW: period_lo = d;
      REG_PHIGH: begin
        period_hi = d;
        // Restart the channel on the trigger bit
        if (d[7]) begin
          chan_on = 1'b1;
          if (length_cnt == 0) length_cnt = LengthFull - {1'b0, duty_cfg[5:0]};
          vol        = env_cfg[7:4];
          env_timer  = (env_cfg[2:0] != 0) ? {1'b0, env_cfg[2:0]} : PaceZero;
          env_done   = 1'b0;
          sweep_len  = sweep_cfg[6:4];
          sweep_cnt  = (sweep_cfg[6:4] != 0) ? {1'b0, sweep_cfg[6:4]} : PaceZero;
          freq_timer = timer_load();
          wave_pos   = '0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [7:0] read_register(logic [2:0] off);
    case (off)
      REG_SWEEP:   return sweep_cfg;
      REG_DUTYLEN: return duty_cfg & DutyReadMask;
      REG_ENV:     return env_cfg;
      REG_PLOW:    return 8'h00;
      REG_PHIGH:   return period_hi & HighReadMask;
      default:     return UnmappedRead;
    endcase
  endfunction

  task automatic apply_transaction(logic [1:0] k, logic [2:0] off, logic [7:0] d,
                                   logic [2:0] seq, output result_t res);
    res.read_data = 8'h00;
    case (k)
      KIND_TICK:  tick_period();
      KIND_FRAME: step_frame(seq);
      KIND_WRITE: write_register(off, d);
      default:    res.read_data = read_register(off);
    endcase
    res.sample     = level;
    res.channel_on = chan_on;
  endtask

  task automatic note_failure(string what, int unsigned want, int unsigned got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    end
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      clear_channel();
      channel_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        apply_transaction(kind_i, reg_offset_i, write_data_i, seq_step_i, want);
        channel_results.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (channel_results.size() == 0) begin
          note_failure("unexpected result", 0, 1);
        end else begin
          want = channel_results.pop_front();
          if (sample_i !== want.sample)
            note_failure("sample", 32'(want.sample), 32'(sample_i));
          if (read_data_i !== want.read_data)
            note_failure("read_data", 32'(want.read_data), 32'(read_data_i));
          if (channel_on_i !== want.channel_on)
            note_failure("channel_on", 32'(want.channel_on), 32'(channel_on_i));
        end
      end
    end
    error_count_o <= fail_count;
    pending_o     <= channel_results.size();
  end

endmodule

@@ tb/pulse_channel_with_sweep_unit_tb.sv @@
module pulse_channel_with_sweep_unit_tb;
  import pcs_pkg::*;

  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned IdlePct    = 17;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid     = 1'b0;
  logic [1:0]        kind         = '0;
  logic [2:0]        reg_offset   = '0;
  logic [7:0]        write_data   = '0;
  logic [2:0]        seq_step     = '0;
  logic              out_ready    = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic signed [4:0] sample;
  logic [7:0]        read_data;
  logic              channel_on;

  int unsigned error_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  logic        idling = 1'b1;
  logic [2:0]  frame_seq = '0;

  always #2 clk_i = ~clk_i;

  pulse_channel_with_sweep_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .kind_i       (kind),
    .reg_offset_i (reg_offset),
    .write_data_i (write_data),
    .seq_step_i   (seq_step),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .sample_o     (sample),
    .read_data_o  (read_data),
    .channel_on_o (channel_on)
  );

  pulse_channel_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .kind_i        (kind),
    .reg_offset_i  (reg_offset),
    .write_data_i  (write_data),
    .seq_step_i    (seq_step),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .sample_i      (sample),
    .read_data_i   (read_data),
    .channel_on_i  (channel_on),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_ready <= !idling || ($urandom_range(99) >= IdlePct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one transaction and hold it until accepted
  task automatic send_item(logic [1:0] k, logic [2:0] off, logic [7:0] d,
                           logic [2:0] seq);
    @(negedge clk_i);
    while (idling && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    reg_offset <= off;
    write_data <= d;
    seq_step   <= seq;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  // Hold off the sender until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Lean periods toward the top so the waveform moves within a burst
  function automatic logic [7:0] shape_data(logic [2:0] off);
    logic [7:0] d;
    d = 8'($urandom);
    if (off == REG_PLOW && $urandom_range(99) < 75) d[7:3] = 5'h1F;
    if (off == REG_PHIGH && $urandom_range(99) < 75) d[2:0] = 3'h7;
    return d;
  endfunction

  // Program all five registers and trigger
  task automatic start_note();
    send_item(KIND_WRITE, REG_SWEEP, shape_data(REG_SWEEP), 3'($urandom));
    send_item(KIND_WRITE, REG_DUTYLEN, shape_data(REG_DUTYLEN), 3'($urandom));
    send_item(KIND_WRITE, REG_ENV, shape_data(REG_ENV), 3'($urandom));
    send_item(KIND_WRITE, REG_PLOW, shape_data(REG_PLOW), 3'($urandom));
    send_item(KIND_WRITE, REG_PHIGH, shape_data(REG_PHIGH) | 8'h80, 3'($urandom));
  endtask

  // Mostly ticks and in-order frame steps, some register traffic
  task automatic play_item();
    int unsigned r;
    logic [2:0]  off;
    r   = $urandom_range(99);
    off = 3'($urandom_range(4));
    if (r < 50) begin
      send_item(KIND_TICK, 3'($urandom), 8'($urandom), 3'($urandom));
    end else if (r < 72) begin
      if ($urandom_range(99) < 10) frame_seq = 3'($urandom);
      send_item(KIND_FRAME, 3'($urandom), 8'($urandom), frame_seq);
      frame_seq = frame_seq + 3'd1;
    end else if (r < 88) begin
      send_item(KIND_WRITE, off, shape_data(off), 3'($urandom));
    end else begin
      send_item(KIND_READ, 3'($urandom), 8'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    int unsigned episode;
    int unsigned burst;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sweep pace set from zero, shortest length, loudest volume, top period
    send_item(KIND_WRITE, REG_SWEEP, 8'h7F, 3'd0);
    send_item(KIND_WRITE, REG_DUTYLEN, 8'hFF, 3'd0);
    send_item(KIND_WRITE, REG_ENV, 8'hF8, 3'd0);
    send_item(KIND_WRITE, REG_PLOW, 8'hFF, 3'd0);
    send_item(KIND_WRITE, REG_PHIGH, 8'hC7, 3'd0);
    repeat (6) send_item(KIND_TICK, 3'd0, 8'h00, 3'd0);
    // Length runs out, then a frame step while off
    send_item(KIND_FRAME, 3'd0, 8'h00, 3'd0);
    send_item(KIND_FRAME, 3'd0, 8'h00, 3'd7);
    // Read every offset, mapped and not, then an unmapped write
    for (int o = 0; o < 8; o++) send_item(KIND_READ, 3'(o), 8'h00, 3'd0);
    send_item(KIND_WRITE, 3'd5, 8'hFF, 3'd0);
    // Clear sweep pace, then an upward sweep that overflows
    send_item(KIND_WRITE, REG_SWEEP, 8'h00, 3'd0);
    send_item(KIND_WRITE, REG_SWEEP, 8'h10, 3'd0);
    send_item(KIND_WRITE, REG_PHIGH, 8'h87, 3'd0);
    send_item(KIND_FRAME, 3'd0, 8'h00, 3'd2);
    send_item(KIND_FRAME, 3'd0, 8'h00, 3'd6);

    episode = 0;
    while (items_sent < ItemTarget) begin
      idling = !(items_sent >= 600 && items_sent < 900);
      if ($urandom_range(99) < 85) begin
        start_note();
        burst = $urandom_range(80, 20);
        repeat (burst) play_item();
      end else begin
        repeat ($urandom_range(12, 4)) begin
          send_item(2'($urandom), 3'($urandom), 8'($urandom), 3'($urandom));
        end
      end
      episode++;
      if (episode == 10 || $urandom_range(99) < 5) wait_drained();
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
